FILE: rtl/ectp_pkg.sv
// Package: shared constants and types for the conserved-to-primitive converter.
`timescale 1ns / 1ps

package ectp_pkg;

    localparam int LANES      = 3;
    localparam int DIV_W      = 32;
    localparam int DIV_STAGES = 32;
    localparam int GAMMA_W    = 19;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd109227;
    localparam logic [GAMMA_W:0]   GAMMA_ONE   = 20'd65536;

    // Register index taken from byte address bit 2.
    localparam logic REG_GAMMA = 1'b0;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    // Per-cell data that rides alongside the divider lanes.
    typedef struct packed {
        logic [31:0]      density;
        logic [31:0]      energy;
        logic             zero;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } side_t;

endpackage

FILE: rtl/ectp_if.sv
// Interfaces: conserved-cell input channel and primitive-result output channel.
`timescale 1ns / 1ps

interface ectp_cons_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] total_energy;

    modport source (output valid, density, momentum_x, momentum_y, momentum_z, total_energy,
                    input ready);
    modport sink   (input valid, density, momentum_x, momentum_y, momentum_z, total_energy,
                    output ready);
endinterface

interface ectp_prim_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] prim_density;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic        [30:0] speed_squared;
    logic signed [31:0] pressure;
    logic        [1:0]  status;

    modport source (output valid, prim_density, velocity_x, velocity_y, velocity_z,
                    speed_squared, pressure, status, input ready);
    modport sink   (input valid, prim_density, velocity_x, velocity_y, velocity_z,
                    speed_squared, pressure, status, output ready);
endinterface

FILE: rtl/ectp_div.sv
// Pipelined restoring divider: three lanes sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps

module ectp_div
    import ectp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [DIV_W-1:0]            divisor,
    input  logic [LANES-1:0][DIV_W-1:0] rem_in,
    input  logic [LANES-1:0][DIV_W-1:0] low_in,
    input  side_t                       side_in,
    output logic                        out_valid,
    output logic [LANES-1:0][DIV_W-1:0] quot,
    output side_t                       side_out
);

    logic [DIV_STAGES:0]                         s_v;
    logic [DIV_STAGES:0][DIV_W-1:0]              s_d;
    logic [DIV_STAGES:0][LANES-1:0][DIV_W-1:0]   s_rem;
    logic [DIV_STAGES:0][LANES-1:0][DIV_W-1:0]   s_low;
    logic [DIV_STAGES:0][LANES-1:0][DIV_W-1:0]   s_q;
    side_t                                       s_side [DIV_STAGES+1];

    logic                                        v_reg    [DIV_STAGES];
    logic [DIV_W-1:0]                            d_reg    [DIV_STAGES];
    logic [LANES-1:0][DIV_W-1:0]                 rem_reg  [DIV_STAGES];
    logic [LANES-1:0][DIV_W-1:0]                 low_reg  [DIV_STAGES];
    logic [LANES-1:0][DIV_W-1:0]                 q_reg    [DIV_STAGES];
    side_t                                       side_reg [DIV_STAGES];

    assign s_v[0]    = in_valid;
    assign s_d[0]    = divisor;
    assign s_rem[0]  = rem_in;
    assign s_low[0]  = low_in;
    assign s_q[0]    = '0;
    assign s_side[0] = side_in;

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        logic [LANES-1:0][DIV_W-1:0] rem_next;
        logic [LANES-1:0][DIV_W-1:0] low_next;
        logic [LANES-1:0][DIV_W-1:0] q_next;

        always_comb
        begin
            logic [DIV_W:0] t;
            logic [DIV_W:0] diff;
            logic           ge;
            for (int l = 0; l < LANES; l++)
            begin
                t    = {s_rem[j][l], s_low[j][l][DIV_W-1]};
                diff = t - {1'b0, s_d[j]};
                ge   = (t >= {1'b0, s_d[j]});
                rem_next[l] = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
                low_next[l] = {s_low[j][l][DIV_W-2:0], 1'b0};
                q_next[l]   = {s_q[j][l][DIV_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= s_v[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[j]    <= s_d[j];
                rem_reg[j]  <= rem_next;
                low_reg[j]  <= low_next;
                q_reg[j]    <= q_next;
                side_reg[j] <= s_side[j];
            end
        end

        assign s_v[j+1]    = v_reg[j];
        assign s_d[j+1]    = d_reg[j];
        assign s_rem[j+1]  = rem_reg[j];
        assign s_low[j+1]  = low_reg[j];
        assign s_q[j+1]    = q_reg[j];
        assign s_side[j+1] = side_reg[j];
    end

    assign out_valid = s_v[DIV_STAGES];
    assign quot      = s_q[DIV_STAGES];
    assign side_out  = s_side[DIV_STAGES];

endmodule

FILE: rtl/euler_conserved_to_primitive.sv
// Top level: ideal-gas Euler conserved-to-primitive converter with APB gamma register.
`timescale 1ns / 1ps
//
//  Channel   Direction  Beat contents
//  -------   ---------  ------------------------------------------------------------
//  cons      in         density, momentum_x/y/z, total_energy (signed Q16.16)
//  prim      out        prim_density, velocity_x/y/z, speed_squared, pressure, status
//  APB       in/out     adiabatic_index (gamma, unsigned Q16.16) at byte address 0
//
//  A beat passes 40 register stages: it enters the input stage at its accepting edge
//  and reaches the output register last. The stages are one input stage, 32 divider
//  stages (one quotient bit each, three lanes sharing the density divisor), then
//  velocity, square, sum, product, difference, gamma product and output stages. One
//  beat is accepted every cycle unless stalled. Reset clears all valid bits and loads
//  gamma with five thirds. The whole pipeline advances together; when the output
//  register holds a beat that is not taken, every stage holds and input ready drops.

module euler_conserved_to_primitive
    import ectp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ectp_cons_if.sink          cons,
    ectp_prim_if.source        prim,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [GAMMA_W-1:0] gamma_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GAMMA) ? {{(32-GAMMA_W){1'b0}}, gamma_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamma_reg <= GAMMA_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_GAMMA))
            gamma_reg <= pwdata[GAMMA_W-1:0];
    end

    // The pipeline moves as one unit; it stalls only when the output beat waits.
    logic adv;
    logic o_v_reg;

    assign adv        = !o_v_reg || prim.ready;
    assign cons.ready = adv;

    // ------------------------------------------------------------------
    // Stage A: magnitudes, signs, zero and overflow detection.
    // The quotient exceeds 32 bits exactly when |m| / 2^16 >= |rho|.
    // ------------------------------------------------------------------
    logic [31:0]             mom [LANES];
    logic [LANES-1:0][31:0]  mag_next;
    logic [LANES-1:0]        neg_next;
    logic [LANES-1:0]        ovf_next;
    logic [31:0]             rho_mag_next;

    assign mom[0] = cons.momentum_x;
    assign mom[1] = cons.momentum_y;
    assign mom[2] = cons.momentum_z;

    always_comb
    begin
        rho_mag_next = cons.density[31] ? (32'd0 - cons.density) : cons.density;
        for (int l = 0; l < LANES; l++)
        begin
            mag_next[l] = mom[l][31] ? (32'd0 - mom[l]) : mom[l];
            neg_next[l] = mom[l][31] ^ cons.density[31];
            ovf_next[l] = ({16'd0, mag_next[l][31:16]} >= rho_mag_next);
        end
    end

    logic                    a_v_reg;
    logic [31:0]             a_rho_reg;
    logic [31:0]             a_en_reg;
    logic [31:0]             a_rho_mag_reg;
    logic [LANES-1:0][31:0]  a_mag_reg;
    logic [LANES-1:0]        a_neg_reg;
    logic [LANES-1:0]        a_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (adv)
            a_v_reg <= cons.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_rho_reg     <= cons.density;
            a_en_reg      <= cons.total_energy;
            a_rho_mag_reg <= rho_mag_next;
            a_mag_reg     <= mag_next;
            a_neg_reg     <= neg_next;
            a_ovf_reg     <= ovf_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: (|m| * 2^16) / |rho|, 32 quotient bits, one per stage.
    // ------------------------------------------------------------------
    logic [LANES-1:0][DIV_W-1:0] div_rem_in;
    logic [LANES-1:0][DIV_W-1:0] div_low_in;
    side_t                       div_side_in;
    logic                        div_v;
    logic [LANES-1:0][DIV_W-1:0] div_q;
    side_t                       div_side;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            div_rem_in[l] = {16'd0, a_mag_reg[l][31:16]};
            div_low_in[l] = {a_mag_reg[l][15:0], 16'd0};
        end
        div_side_in.density = a_rho_reg;
        div_side_in.energy  = a_en_reg;
        div_side_in.zero    = (a_rho_reg == 32'd0);
        div_side_in.neg     = a_neg_reg;
        div_side_in.ovf     = a_ovf_reg;
    end

    ectp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_v_reg),
        .divisor   (a_rho_mag_reg),
        .rem_in    (div_rem_in),
        .low_in    (div_low_in),
        .side_in   (div_side_in),
        .out_valid (div_v),
        .quot      (div_q),
        .side_out  (div_side)
    );

    // ------------------------------------------------------------------
    // Stage B: signed, saturated velocities.
    // ------------------------------------------------------------------
    logic [LANES-1:0][31:0] vel_next;
    logic                   vsat_next;

    always_comb
    begin
        vsat_next = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            if (div_side.ovf[l])
            begin
                vsat_next   = 1'b1;
                vel_next[l] = div_side.neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else if (div_side.neg[l])
            begin
                if (div_q[l] > 32'h8000_0000)
                begin
                    vsat_next   = 1'b1;
                    vel_next[l] = 32'h8000_0000;
                end
                else
                    vel_next[l] = 32'd0 - div_q[l];
            end
            else if (div_q[l][31])
            begin
                vsat_next   = 1'b1;
                vel_next[l] = 32'h7FFF_FFFF;
            end
            else
                vel_next[l] = div_q[l];
        end
    end

    logic                   b_v_reg;
    logic [LANES-1:0][31:0] b_vel_reg;
    logic                   b_sat_reg;
    logic [31:0]            b_rho_reg;
    logic [31:0]            b_en_reg;
    logic                   b_zero_reg;

    // ------------------------------------------------------------------
    // Stage C: squares of the velocity magnitudes.
    // ------------------------------------------------------------------
    logic [LANES-1:0][63:0] sq_next;

    always_comb
    begin
        logic [31:0] m;
        for (int l = 0; l < LANES; l++)
        begin
            m          = b_vel_reg[l][31] ? (32'd0 - b_vel_reg[l]) : b_vel_reg[l];
            sq_next[l] = 64'(m) * 64'(m);
        end
    end

    logic                   c_v_reg;
    logic [LANES-1:0][63:0] c_sq_reg;
    logic [LANES-1:0][31:0] c_vel_reg;
    logic                   c_sat_reg;
    logic [31:0]            c_rho_reg;
    logic [31:0]            c_en_reg;
    logic                   c_zero_reg;

    // ------------------------------------------------------------------
    // Stage D: sum of squares, scaled and clamped to 31 bits.
    // ------------------------------------------------------------------
    logic [63:0] sum_sq;
    logic [30:0] ssq_next;
    logic        ssat_next;

    assign sum_sq = c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];

    always_comb
    begin
        if (sum_sq[63:47] != '0)
        begin
            ssq_next  = 31'h7FFF_FFFF;
            ssat_next = 1'b1;
        end
        else
        begin
            ssq_next  = sum_sq[46:16];
            ssat_next = 1'b0;
        end
    end

    logic                   d_v_reg;
    logic [30:0]            d_ssq_reg;
    logic [LANES-1:0][31:0] d_vel_reg;
    logic                   d_sat_reg;
    logic [31:0]            d_rho_reg;
    logic [31:0]            d_en_reg;
    logic                   d_zero_reg;

    // ------------------------------------------------------------------
    // Stage E: density times squared speed.
    // ------------------------------------------------------------------
    logic signed [63:0] prod_next;

    assign prod_next = $signed(d_rho_reg) * $signed({1'b0, d_ssq_reg});

    logic                   e_v_reg;
    logic signed [63:0]     e_prod_reg;
    logic [30:0]            e_ssq_reg;
    logic [LANES-1:0][31:0] e_vel_reg;
    logic                   e_sat_reg;
    logic [31:0]            e_rho_reg;
    logic [31:0]            e_en_reg;
    logic                   e_zero_reg;

    // ------------------------------------------------------------------
    // Stage F: energy difference n and gamma - 1 as sign and magnitude.
    // ------------------------------------------------------------------
    logic [63:0]    n_val;
    logic [GAMMA_W:0] g_val;
    logic [63:0]    nm_next;
    logic [GAMMA_W-1:0] gm_next;
    logic           pneg_next;

    assign n_val     = {{15{e_en_reg[31]}}, e_en_reg, 17'd0} - e_prod_reg;
    assign g_val     = {1'b0, gamma_reg} - GAMMA_ONE;
    assign nm_next   = n_val[63] ? (64'd0 - n_val) : n_val;
    assign gm_next   = g_val[GAMMA_W] ? GAMMA_W'(GAMMA_ONE - g_val) - GAMMA_W'(GAMMA_ONE)
                                      : g_val[GAMMA_W-1:0];
    assign pneg_next = n_val[63] ^ g_val[GAMMA_W];

    logic                   f_v_reg;
    logic [63:0]            f_nm_reg;
    logic [GAMMA_W-1:0]     f_gm_reg;
    logic                   f_pneg_reg;
    logic [30:0]            f_ssq_reg;
    logic [LANES-1:0][31:0] f_vel_reg;
    logic                   f_sat_reg;
    logic [31:0]            f_rho_reg;
    logic                   f_zero_reg;

    // ------------------------------------------------------------------
    // Stage G: gamma factor times the upper and lower halves of |n|.
    // ------------------------------------------------------------------
    logic [50:0] ph_next;
    logic [50:0] pl_next;

    assign ph_next = 51'(f_gm_reg) * 51'(f_nm_reg[63:32]);
    assign pl_next = 51'(f_gm_reg) * 51'(f_nm_reg[31:0]);

    logic                   g_v_reg;
    logic [50:0]            g_ph_reg;
    logic [50:0]            g_pl_reg;
    logic                   g_pneg_reg;
    logic [30:0]            g_ssq_reg;
    logic [LANES-1:0][31:0] g_vel_reg;
    logic                   g_sat_reg;
    logic [31:0]            g_rho_reg;
    logic                   g_zero_reg;

    // ------------------------------------------------------------------
    // Stage H: pressure, clamped, and the output register.
    // ------------------------------------------------------------------
    logic [51:0] qsum;
    logic [50:0] qv;
    logic [31:0] p_next;
    logic        psat_next;

    assign qsum = {1'b0, g_ph_reg} + {33'd0, g_pl_reg[50:32]};
    assign qv   = qsum[51:1];

    always_comb
    begin
        psat_next = 1'b0;
        if (g_pneg_reg)
        begin
            if (qv > 51'h8000_0000)
            begin
                psat_next = 1'b1;
                p_next    = 32'h8000_0000;
            end
            else
                p_next = 32'd0 - qv[31:0];
        end
        else if (qv > 51'h7FFF_FFFF)
        begin
            psat_next = 1'b1;
            p_next    = 32'h7FFF_FFFF;
        end
        else
            p_next = qv[31:0];
    end

    logic [31:0]            o_rho_reg;
    logic [LANES-1:0][31:0] o_vel_reg;
    logic [30:0]            o_ssq_reg;
    logic [31:0]            o_p_reg;
    logic [1:0]             o_status_reg;

    // Valid bits of stages B through H.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_v_reg <= div_v;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            o_v_reg <= g_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_vel_reg  <= vel_next;
            b_sat_reg  <= vsat_next;
            b_rho_reg  <= div_side.density;
            b_en_reg   <= div_side.energy;
            b_zero_reg <= div_side.zero;

            c_sq_reg   <= sq_next;
            c_vel_reg  <= b_vel_reg;
            c_sat_reg  <= b_sat_reg;
            c_rho_reg  <= b_rho_reg;
            c_en_reg   <= b_en_reg;
            c_zero_reg <= b_zero_reg;

            d_ssq_reg  <= ssq_next;
            d_vel_reg  <= c_vel_reg;
            d_sat_reg  <= c_sat_reg | ssat_next;
            d_rho_reg  <= c_rho_reg;
            d_en_reg   <= c_en_reg;
            d_zero_reg <= c_zero_reg;

            e_prod_reg <= prod_next;
            e_ssq_reg  <= d_ssq_reg;
            e_vel_reg  <= d_vel_reg;
            e_sat_reg  <= d_sat_reg;
            e_rho_reg  <= d_rho_reg;
            e_en_reg   <= d_en_reg;
            e_zero_reg <= d_zero_reg;

            f_nm_reg   <= nm_next;
            f_gm_reg   <= gm_next;
            f_pneg_reg <= pneg_next;
            f_ssq_reg  <= e_ssq_reg;
            f_vel_reg  <= e_vel_reg;
            f_sat_reg  <= e_sat_reg;
            f_rho_reg  <= e_rho_reg;
            f_zero_reg <= e_zero_reg;

            g_ph_reg   <= ph_next;
            g_pl_reg   <= pl_next;
            g_pneg_reg <= f_pneg_reg;
            g_ssq_reg  <= f_ssq_reg;
            g_vel_reg  <= f_vel_reg;
            g_sat_reg  <= f_sat_reg;
            g_rho_reg  <= f_rho_reg;
            g_zero_reg <= f_zero_reg;

            // A cell with zero density reports all fields as zero.
            if (g_zero_reg)
            begin
                o_rho_reg    <= '0;
                o_vel_reg    <= '0;
                o_ssq_reg    <= '0;
                o_p_reg      <= '0;
                o_status_reg <= STATUS_ZERO;
            end
            else
            begin
                o_rho_reg    <= g_rho_reg;
                o_vel_reg    <= g_vel_reg;
                o_ssq_reg    <= g_ssq_reg;
                o_p_reg      <= p_next;
                o_status_reg <= (g_sat_reg || psat_next) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign prim.valid         = o_v_reg;
    assign prim.prim_density  = o_rho_reg;
    assign prim.velocity_x    = o_vel_reg[0];
    assign prim.velocity_y    = o_vel_reg[1];
    assign prim.velocity_z    = o_vel_reg[2];
    assign prim.speed_squared = o_ssq_reg;
    assign prim.pressure      = o_p_reg;
    assign prim.status        = o_status_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        prim.valid && (prim.status == STATUS_ZERO) |->
            (prim.velocity_x == 0) && (prim.velocity_y == 0) && (prim.velocity_z == 0) &&
            (prim.speed_squared == 0) && (prim.pressure == 0))
        else $error("zero-density beat carries nonzero results");

    a_nonzero_density: assert property (@(posedge clk) disable iff (!rst_n)
        prim.valid && (prim.status != STATUS_ZERO) |-> (prim.prim_density != 0))
        else $error("zero density reported without zero status");

    a_enter_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cons.valid && cons.ready |=> a_v_reg)
        else $error("accepted beat lost at the input stage");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(a_v_reg) && $stable(b_v_reg) && $stable(g_v_reg)))
        else $error("pipeline moved during a stall");

endmodule
